// File: hw/rtl/pfs_pkg.sv
// Shared types and constants for the page allocator free-stack block.
// No dependencies; imported by every module of the block except pfs_ram.
package pfs_pkg;

  localparam int FREE_DEPTH   = 1024;
  localparam int PAGE_ID_BITS = 20;
  localparam int HW_FREE_CAP  = 1021;
  localparam int FREE_CAP     = (FREE_DEPTH < HW_FREE_CAP) ? FREE_DEPTH : HW_FREE_CAP;

  localparam int ID_W   = 20;
  localparam int FC_W   = 11;
  localparam int ADDR_W = $clog2(FREE_DEPTH);
  localparam int CNT_W  = $clog2(FREE_DEPTH + 1);

  localparam logic [ID_W-1:0] ID_MAX = ID_W'((64'd1 << PAGE_ID_BITS) - 64'd1);

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_CHECK = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SRC_ID   = 2'd0,
    SRC_RAM  = 2'd1,
    SRC_HWNX = 2'd2,
    SRC_ZERO = 2'd3
  } res_src_t;

  // Controller to datapath.
  typedef struct packed {
    logic     latch_in;
    logic     hw_inc;
    logic     used_dec;
    logic     used_inc;
    logic     rd_pop;
    logic     scan_start;
    logic     scan_step;
    logic     res_load;
    res_src_t res_src;
    status_t  res_st;
    logic     load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    func_t func;
    logic  id_ok;
    logic  used_zero;
    logic  hw_max;
    logic  stack_full;
    logic  hit;
    logic  scan_end;
    logic  out_free;
  } stat_t;

endpackage

// File: hw/rtl/pfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// File: hw/rtl/pfs_ctrl.sv
// Sequencing state machine of the page allocator.
// Depends on pfs_pkg; drives pfs_dp through cmd_t, reads stat_t.
module pfs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pfs_pkg::stat_t stat,
  output pfs_pkg::cmd_t  cmd
);
  import pfs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.res_src = SRC_ID;
        cmd.res_st  = ST_OK;
        state_nxt   = S_RESP;
        unique case (stat.func)
          FN_ALLOC: begin
            if (!stat.used_zero) begin
              cmd.rd_pop   = 1'b1;
              cmd.used_dec = 1'b1;
              state_nxt    = S_POP;
            end else if (stat.hw_max) begin
              cmd.res_load = 1'b1;
              cmd.res_src  = SRC_ZERO;
              cmd.res_st   = ST_EXHAUSTED;
            end else begin
              cmd.hw_inc   = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_src  = SRC_HWNX;
            end
          end
          FN_FREE: begin
            if (!stat.id_ok) begin
              cmd.res_load = 1'b1;
              cmd.res_st   = ST_INVALID;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          FN_CHECK: begin
            cmd.res_load = 1'b1;
            cmd.res_st   = stat.id_ok ? ST_OK : ST_INVALID;
          end
          default: begin
            cmd.res_load = 1'b1;
            cmd.res_st   = ST_INVALID;
          end
        endcase
      end
      S_POP: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = SRC_RAM;
        cmd.res_st   = ST_OK;
        state_nxt    = S_RESP;
      end
      S_SCAN: begin
        cmd.res_src = SRC_ID;
        cmd.res_st  = ST_OK;
        priority if (stat.hit) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_RESP;
        end else if (stat.scan_end) begin
          cmd.res_load = 1'b1;
          if (stat.stack_full) begin
            cmd.res_st = ST_FULL;
          end else begin
            cmd.used_inc = 1'b1;
          end
          state_nxt = S_RESP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/pfs_dp.sv
// Datapath of the page allocator: counters, free-stack memory, scan and result word.
// Depends on pfs_pkg and pfs_ram; steered by pfs_ctrl through cmd_t.
module pfs_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pfs_pkg::cmd_t             cmd,
  output pfs_pkg::stat_t            stat,
  input  logic [1:0]                in_func,
  input  logic [pfs_pkg::ID_W-1:0]  in_page_id,
  input  logic                      out_stall,
  output logic                      out_valid,
  output logic [pfs_pkg::ID_W-1:0]  out_result_page,
  output logic [1:0]                out_status,
  output logic [pfs_pkg::ID_W-1:0]  out_page_count,
  output logic [pfs_pkg::FC_W-1:0]  out_free_count
);
  import pfs_pkg::*;

  func_t             func_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   hw_r, hw_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic              hit_r, hit_nxt;
  logic [ID_W-1:0]   res_r;
  status_t           st_r;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_res_r, out_pc_r;
  status_t           out_st_r;
  logic [FC_W-1:0]   out_fc_r;

  logic [CNT_W-1:0]  used_m1;
  logic [ID_W-1:0]   hw_inc1;
  logic              scan_issue;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ID_W-1:0]   rd_data;
  logic [ID_W-1:0]   res_val;

  assign used_m1    = used_r - CNT_W'(1);
  assign hw_inc1    = hw_r + ID_W'(1);
  assign scan_issue = cmd.scan_step && (idx_r != used_r);
  assign rd_en      = cmd.rd_pop || scan_issue;
  assign rd_addr    = cmd.rd_pop ? used_m1[ADDR_W-1:0] : idx_r[ADDR_W-1:0];

  pfs_ram #(
    .WIDTH (ID_W),
    .DEPTH (FREE_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd.used_inc),
    .wr_addr (used_r[ADDR_W-1:0]),
    .wr_data (id_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    unique case (cmd.res_src)
      SRC_ID:   res_val = id_r;
      SRC_RAM:  res_val = rd_data;
      SRC_HWNX: res_val = hw_inc1;
      SRC_ZERO: res_val = '0;
      default:  res_val = id_r;
    endcase
  end

  // Counters and scan bookkeeping.
  always_comb begin
    hw_nxt   = cmd.hw_inc ? hw_inc1 : hw_r;
    used_nxt = used_r;
    if (cmd.used_dec) begin
      used_nxt = used_m1;
    end else if (cmd.used_inc) begin
      used_nxt = used_r + CNT_W'(1);
    end
    idx_nxt  = idx_r;
    pend_nxt = scan_issue;
    hit_nxt  = hit_r || (pend_r && (rd_data == id_r));
    if (cmd.scan_start) begin
      idx_nxt  = '0;
      pend_nxt = 1'b0;
      hit_nxt  = 1'b0;
    end else if (scan_issue) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  // Hold the result word while the consumer stalls.
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r        <= '0;
      used_r      <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      hw_r        <= hw_nxt;
      used_r      <= used_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r <= func_t'(in_func);
      // keep only the id bits in use
      id_r   <= in_page_id & ID_MAX;
    end
    if (cmd.res_load) begin
      res_r <= res_val;
      st_r  <= cmd.res_st;
    end
    if (cmd.load_out) begin
      out_res_r <= res_r;
      out_st_r  <= st_r;
      out_pc_r  <= hw_r;
      out_fc_r  <= FC_W'(used_r);
    end
  end

  assign stat.func       = func_r;
  assign stat.id_ok      = (id_r != '0) && (id_r <= hw_r);
  assign stat.used_zero  = (used_r == '0);
  assign stat.hw_max     = (hw_r >= ID_MAX);
  assign stat.stack_full = (used_r >= CNT_W'(FREE_CAP));
  assign stat.hit        = hit_r;
  assign stat.scan_end   = (idx_r == used_r) && !pend_r;

  assign out_valid       = out_valid_r;
  assign out_result_page = out_res_r;
  assign out_status      = out_st_r;
  assign out_page_count  = out_pc_r;
  assign out_free_count  = out_fc_r;

endmodule

// File: hw/rtl/page_allocator_free_stack_unit.sv
// Page allocator with a LIFO free stack; top level joining pfs_ctrl and pfs_dp.
// Path from accepted word to result word: check, invalid and fresh allocate go through
// EXEC and RESP, allocate from the stack adds POP for the stack read, and free runs a
// duplicate scan over the used ids on the stack, reading one entry per cycle through the
// single read port. One word in flight: no new word is taken until the result is loaded.
// Synchronous active-low reset clears counters and control; the stack memory is not cleared.
module page_allocator_free_stack_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_func,
  input  logic [pfs_pkg::ID_W-1:0] in_page_id,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [pfs_pkg::ID_W-1:0] out_result_page,
  output logic [1:0]               out_status,
  output logic [pfs_pkg::ID_W-1:0] out_page_count,
  output logic [pfs_pkg::FC_W-1:0] out_free_count
);
  import pfs_pkg::*;

  // Command and status bundles between the controller and the datapath.
  cmd_t  cmd;
  stat_t stat;

  // Controller: accept a word in idle, branch on func, run the stack scan,
  // and wait until the output register can take the result word.
  pfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: high-water count, stack fill count, stack memory, scan
  // pointer and hit flag, result staging and the output register.
  pfs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_page_id      (in_page_id),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_page (out_result_page),
    .out_status      (out_status),
    .out_page_count  (out_page_count),
    .out_free_count  (out_free_count)
  );

  // Never overwrite a result word that is still stalled.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> stat.out_free)
    else $error("result word overwritten while stalled");

  // Never bump the page count past the largest id.
  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hw_inc |-> !stat.hw_max)
    else $error("page count bumped at id limit");

  // Never push onto a full stack.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.used_inc |-> !stat.stack_full)
    else $error("push on full free stack");

  // Exhaustion always returns page zero.
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_EXHAUSTED)) |-> (out_result_page == '0))
    else $error("exhausted result carries nonzero page");

endmodule
